### rtl/core/serial_frame_extractor_unit_assert.svh
// Assertion macros shared by the frame extractor RTL.
`ifndef SERIAL_FRAME_EXTRACTOR_UNIT_ASSERT_SVH
`define SERIAL_FRAME_EXTRACTOR_UNIT_ASSERT_SVH
// Property must hold on every clock edge outside reset.
`define SFE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define SFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/sfe_pkg.sv
// Package: types, codes and constants of the frame extractor.
`default_nettype none
package sfe_pkg;
	localparam int STORE_DEPTH_DEF = 1024;
	localparam int MAX_PATTERN_DEF = 4;
	localparam int MAX_FRAME_DEF = 64;

	localparam logic [2:0] REG_FRAME_MODE = 3'd0;
	localparam logic [2:0] REG_LEAD_PAT   = 3'd1;
	localparam logic [2:0] REG_LEAD_CNT   = 3'd2;
	localparam logic [2:0] REG_END_PAT    = 3'd3;
	localparam logic [2:0] REG_END_CNT    = 3'd4;
	localparam logic [2:0] REG_MAX_LEN    = 3'd5;

	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_DELIM = 2'd1;
	localparam logic [1:0] MODE_FIXL  = 2'd2;
	localparam logic [1:0] MODE_FIXLE = 2'd3;

	localparam logic REQ_PUSH = 1'b0;

	typedef struct packed {
		logic [0:0] req_type;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [0:0]  frame_last;
		logic [0:0]  frame_found;
		logic [10:0] fill_level;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAD_ADDR,
		ST_LEAD_CHK,
		ST_END_ADDR,
		ST_END_CHK,
		ST_FIX_ADDR,
		ST_FIX_CHK,
		ST_DECIDE,
		ST_EMIT_ADDR,
		ST_EMIT
	} seq_state_t;
endpackage
`default_nettype wire

### rtl/core/serial_frame_extractor_unit.sv
// Top level: byte ring store with a sequencer that searches and emits frames.
// Channel  | Dir | Handshake            | Payload
// cmd      | in  | start && !busy       | cmd (in_item_t)
// result   | out | strobe, one cycle    | result (out_item_t)
// cfg      | in  | cfg_valid&&cfg_ready | cfg_index, cfg_data
// A push keeps busy low, and the next item may follow at once.
// A request walks the store through the RAM's single read port, each probed
// byte in an address state and then a check state. Up to P lead and P end
// bytes are probed per position; the search is followed by a decide state,
// and each emitted byte by an address and an emit state. busy is high throughout.
// Reset clears head and count, sets config to defaults and the sequencer to idle; the RAM is not cleared.
// The receiver cannot stall: each result is shown for one cycle with strobe.
`default_nettype none
`include "serial_frame_extractor_unit_assert.svh"
module serial_frame_extractor_unit #(
	parameter int STORE_DEPTH = sfe_pkg::STORE_DEPTH_DEF,
	parameter int MAX_PATTERN = sfe_pkg::MAX_PATTERN_DEF,
	parameter int MAX_FRAME   = sfe_pkg::MAX_FRAME_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire sfe_pkg::in_item_t cmd,
	output logic                   strobe,
	output sfe_pkg::out_item_t     result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = AW + 1;
	localparam int PW = $clog2(MAX_PATTERN + 1);
	localparam int FW = $clog2(MAX_FRAME + 1);

	// Config registers
	logic [1:0]  mode_q;
	logic [31:0] lpat_q, epat_q;
	logic [2:0]  lcnt_q, ecnt_q;
	logic [6:0]  mlen_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sfe_pkg::MODE_DELIM;
			lpat_q <= '0;
			lcnt_q <= 3'd1;
			epat_q <= '0;
			ecnt_q <= 3'd1;
			mlen_q <= 7'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfe_pkg::REG_FRAME_MODE: mode_q <= cfg_data[1:0];
				sfe_pkg::REG_LEAD_PAT:   lpat_q <= cfg_data;
				sfe_pkg::REG_LEAD_CNT:   lcnt_q <= cfg_data[2:0];
				sfe_pkg::REG_END_PAT:    epat_q <= cfg_data;
				sfe_pkg::REG_END_CNT:    ecnt_q <= cfg_data[2:0];
				sfe_pkg::REG_MAX_LEN:    mlen_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Effective lengths (saturated)
	logic [FW-1:0] eff_len;
	logic [PW-1:0] lc, ec;
	always_comb begin
		if (mlen_q == 7'd0) begin
			eff_len = FW'(1);
		end else if (32'(mlen_q) > 32'(MAX_FRAME)) begin
			eff_len = FW'(MAX_FRAME);
		end else begin
			eff_len = FW'(mlen_q);
		end
		lc = (32'(lcnt_q) > 32'(MAX_PATTERN)) ? PW'(MAX_PATTERN) : PW'(lcnt_q);
		ec = (32'(ecnt_q) > 32'(MAX_PATTERN)) ? PW'(MAX_PATTERN) : PW'(ecnt_q);
	end

	function automatic logic [7:0] pat_byte(input logic [31:0] p, input logic [PW-1:0] m);
		logic [7:0] b;
		b = 8'd0;
		if (32'(m) < 32'd4) begin
			b = p[8*m[1:0] +: 8];
		end
		return b;
	endfunction

	// Ring state
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;

	// Sequencer registers
	sfe_pkg::seq_state_t st_q, st_d;
	logic [CW-1:0] n_q, n_d;       // candidate position
	logic [PW-1:0] m_q, m_d;       // pattern byte index
	logic [CW-1:0] begin_q, begin_d;
	logic [CW-1:0] flen_q, flen_d;
	logic [CW-1:0] cons_q, cons_d;
	logic          found_q, found_d;
	logic          fixe_q, fixe_d; // checking the ending byte in mode 3
	logic [CW-1:0] k_q, k_d;       // emit index

	// RAM port signals
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_rdata;
	logic [CW-1:0] rd_off;

	sfe_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd.data_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Push path
	logic          acc, is_push, full;
	logic [CW-1:0] depth_c;
	assign depth_c = CW'(STORE_DEPTH);
	assign acc     = start && !busy;
	assign is_push = (cmd.req_type == sfe_pkg::REQ_PUSH);
	assign full    = (cnt_q >= depth_c);
	assign ram_we  = acc && is_push;
	assign ram_waddr = full ? '0 : AW'(CW'(head_q) + cnt_q);
	assign ram_raddr = AW'(CW'(head_q) + rd_off);
	assign busy    = (st_q != sfe_pkg::ST_IDLE);

	// Head/count update
	logic [CW-1:0] rem_cnt;
	assign rem_cnt = cnt_q - cons_q;
	logic commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (ram_we) begin
			if (full) begin
				head_q <= '0;
				cnt_q  <= CW'(1);
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end else if (commit) begin
			cnt_q  <= rem_cnt;
			head_q <= (rem_cnt == '0) ? '0 : AW'(CW'(head_q) + cons_q);
		end
	end

	// Sequencer: next state and outputs
	logic [CW-1:0] lsum;
	logic [7:0]    want;
	always_comb begin
		st_d = st_q; n_d = n_q; m_d = m_q; begin_d = begin_q;
		flen_d = flen_q; cons_d = cons_q; found_d = found_q; fixe_d = fixe_q; k_d = k_q;
		rd_off = n_q + CW'(m_q);
		commit = 1'b0;
		strobe = 1'b0;
		result = '0;
		lsum = CW'(lc) + CW'(ec);
		want = 8'd0;
		unique case (st_q)
			sfe_pkg::ST_IDLE: begin
				if (acc && !is_push) begin
					n_d = '0; m_d = '0; found_d = 1'b0; fixe_d = 1'b0; k_d = '0;
					unique case (mode_q)
						sfe_pkg::MODE_RAW: begin
							if (cnt_q != '0) begin
								found_d = 1'b1;
								begin_d = '0;
								flen_d = (cnt_q < CW'(eff_len)) ? cnt_q : CW'(eff_len);
								cons_d = (cnt_q < CW'(eff_len)) ? cnt_q : CW'(eff_len);
							end
							st_d = sfe_pkg::ST_DECIDE;
						end
						sfe_pkg::MODE_DELIM: begin
							if (cnt_q < lsum) begin
								st_d = sfe_pkg::ST_DECIDE;
							end else if (lc == '0) begin
								begin_d = '0;
								if (ec == '0) begin
									st_d = sfe_pkg::ST_DECIDE;
									found_d = (cnt_q > CW'(1));
									flen_d = (cnt_q > CW'(eff_len)) ? CW'(eff_len) : cnt_q;
									cons_d = cnt_q;
								end else begin
									n_d = '0;
									st_d = sfe_pkg::ST_END_ADDR;
								end
							end else begin
								st_d = sfe_pkg::ST_LEAD_ADDR;
							end
						end
						default: begin
							st_d = sfe_pkg::ST_FIX_ADDR;
						end
					endcase
				end
			end
			// Lead search: issue read of byte n+m
			sfe_pkg::ST_LEAD_ADDR: begin
				if (n_q + lsum > cnt_q) begin
					st_d = sfe_pkg::ST_DECIDE;
				end else begin
					st_d = sfe_pkg::ST_LEAD_CHK;
				end
			end
			sfe_pkg::ST_LEAD_CHK: begin
				want = pat_byte(lpat_q, m_q);
				if (ram_rdata != want) begin
					m_d = '0; n_d = n_q + CW'(1);
					st_d = sfe_pkg::ST_LEAD_ADDR;
				end else if (m_q == lc - PW'(1)) begin
					begin_d = n_q;
					m_d = '0;
					if (ec == '0) begin
						found_d = (cnt_q - CW'(1) > n_q);
						flen_d = cnt_q - n_q;
						if (cnt_q - n_q > CW'(eff_len)) flen_d = CW'(eff_len);
						cons_d = cnt_q;
						st_d = sfe_pkg::ST_DECIDE;
					end else begin
						n_d = n_q + CW'(lc);
						st_d = sfe_pkg::ST_END_ADDR;
					end
				end else begin
					m_d = m_q + PW'(1);
					st_d = sfe_pkg::ST_LEAD_ADDR;
				end
			end
			// End search from begin+lc
			sfe_pkg::ST_END_ADDR: begin
				if (n_q + CW'(ec) > cnt_q) begin
					st_d = sfe_pkg::ST_DECIDE;
				end else begin
					st_d = sfe_pkg::ST_END_CHK;
				end
			end
			sfe_pkg::ST_END_CHK: begin
				want = pat_byte(epat_q, m_q);
				if (ram_rdata != want) begin
					m_d = '0; n_d = n_q + CW'(1);
					st_d = sfe_pkg::ST_END_ADDR;
				end else if (m_q == ec - PW'(1)) begin
					found_d = (n_q + CW'(ec) - CW'(1) > begin_q);
					flen_d = n_q + CW'(ec) - begin_q;
					if (n_q + CW'(ec) - begin_q > CW'(eff_len)) flen_d = CW'(eff_len);
					cons_d = n_q + CW'(ec);
					st_d = sfe_pkg::ST_DECIDE;
				end else begin
					m_d = m_q + PW'(1);
					st_d = sfe_pkg::ST_END_ADDR;
				end
			end
			// Fixed modes: check lead byte at n, then (mode 3) end byte at n+L-1
			sfe_pkg::ST_FIX_ADDR: begin
				rd_off = fixe_q ? (n_q + CW'(eff_len) - CW'(1)) : n_q;
				if (n_q + CW'(eff_len) > cnt_q) begin
					st_d = sfe_pkg::ST_DECIDE;
				end else begin
					st_d = sfe_pkg::ST_FIX_CHK;
				end
			end
			sfe_pkg::ST_FIX_CHK: begin
				want = fixe_q ? epat_q[7:0] : lpat_q[7:0];
				if (ram_rdata != want) begin
					fixe_d = 1'b0; n_d = n_q + CW'(1);
					st_d = sfe_pkg::ST_FIX_ADDR;
				end else if (!fixe_q && mode_q == sfe_pkg::MODE_FIXLE) begin
					fixe_d = 1'b1;
					st_d = sfe_pkg::ST_FIX_ADDR;
				end else begin
					found_d = 1'b1;
					begin_d = n_q;
					flen_d = CW'(eff_len);
					cons_d = n_q + CW'(eff_len);
					st_d = sfe_pkg::ST_DECIDE;
				end
			end
			sfe_pkg::ST_DECIDE: begin
				if (!found_q) begin
					strobe = 1'b1;
					result.frame_last = 1'b1;
					result.fill_level = 11'(cnt_q);
					st_d = sfe_pkg::ST_IDLE;
				end else begin
					k_d = '0;
					st_d = sfe_pkg::ST_EMIT_ADDR;
				end
			end
			sfe_pkg::ST_EMIT_ADDR: begin
				rd_off = begin_q + k_q;
				st_d = sfe_pkg::ST_EMIT;
			end
			sfe_pkg::ST_EMIT: begin
				strobe = 1'b1;
				result.frame_byte = ram_rdata;
				result.frame_found = 1'b1;
				result.frame_last = (k_q == flen_q - CW'(1));
				result.fill_level = 11'(rem_cnt);
				k_d = k_q + CW'(1);
				if (k_q == flen_q - CW'(1)) begin
					commit = 1'b1;
					st_d = sfe_pkg::ST_IDLE;
				end else begin
					st_d = sfe_pkg::ST_EMIT_ADDR;
				end
			end
			default: st_d = sfe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sfe_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d; m_q <= m_d; begin_q <= begin_d;
		flen_q <= flen_d; cons_q <= cons_d; found_q <= found_d;
		fixe_q <= fixe_d; k_q <= k_d;
	end

	`SFE_ASSERT(a_cnt_range, cnt_q <= depth_c, "byte count exceeds store depth")
	`SFE_ASSERT(a_no_push_busy, !(ram_we && busy), "push accepted while busy")
	`SFE_ASSERT_NEXT(a_last_idle, strobe && result.frame_last, !busy, "not idle after last result")
	`SFE_ASSERT(a_commit_strobe, !commit || strobe, "commit without a result transfer")
endmodule
`default_nettype wire

### rtl/core/sfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module sfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
